// ===== hw/rtl/cir_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cir_pkg
// Shared types and constants of the collision impulse response pipeline.
// ----------------------------------------------------------------------------
package cir_pkg;

  localparam int DATA_W      = 32;
  localparam int PADDR_W     = 3;
  localparam int RATIO_BITS  = 30;
  localparam int SQRT_STAGES = 32;
  localparam int REST_W      = 15;
  localparam int THR_W       = 16;

  localparam logic [REST_W-1:0] REST_ONE             = 15'd16384;
  localparam logic [REST_W-1:0] RESTITUTION_RESET    = 15'd16384;
  localparam logic [THR_W-1:0]  REST_THRESHOLD_RESET = 16'd7;

  // word index of the registers (paddr bit 2)
  localparam logic REG_RESTITUTION    = 1'b0;
  localparam logic REG_REST_THRESHOLD = 1'b1;

  localparam logic [1:0] MODE_NORMALIZE = 2'd0;
  localparam logic [1:0] MODE_UNIT      = 2'd1;

  typedef logic [2:0][DATA_W-1:0] vec3_t;

  typedef struct packed {
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] vel_a_x;
    logic signed [31:0] vel_a_y;
    logic signed [31:0] vel_a_z;
    logic signed [31:0] vel_b_x;
    logic signed [31:0] vel_b_y;
    logic signed [31:0] vel_b_z;
    logic [31:0]        mass_a;
    logic [31:0]        mass_b;
    logic [1:0]         mode;
  } item_t;

  typedef struct packed {
    logic signed [31:0] new_a_x;
    logic signed [31:0] new_a_y;
    logic signed [31:0] new_a_z;
    logic signed [31:0] new_b_x;
    logic signed [31:0] new_b_y;
    logic signed [31:0] new_b_z;
    logic               collided;
  } result_t;

  // side data that rides along the back half of the pipeline
  typedef struct packed {
    logic  skip;
    vec3_t va;
    vec3_t vb;
    vec3_t u;
  } carry_t;

endpackage
`default_nettype wire

// ===== hw/rtl/cir_delay.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cir_delay
// Fixed-length shift line that keeps side data aligned with a long unit.
// ----------------------------------------------------------------------------
module cir_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);
  logic [W-1:0] line [DEPTH];

  always_ff @(posedge clk) begin
    line[0] <= d;
    for (int k = 1; k < DEPTH; k++) begin
      line[k] <= line[k-1];
    end
  end

  assign q = line[DEPTH-1];
endmodule
`default_nettype wire

// ===== hw/rtl/cir_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cir_sqrt
// Pipelined floor square root of a 64-bit radicand, one root bit per stage.
// ----------------------------------------------------------------------------
module cir_sqrt (
  input  logic        clk,
  input  logic [63:0] rad,
  output logic [31:0] root
);
  import cir_pkg::*;

  logic [33:0] rem_r  [SQRT_STAGES];
  logic [31:0] root_r [SQRT_STAGES];
  logic [63:0] rad_r  [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    logic [33:0] rem_in;
    logic [31:0] root_in;
    logic [63:0] rad_in;
    logic [35:0] cur;
    logic [35:0] trial;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign rad_in  = rad_r[k-1];
    end

    // bring down the next two radicand bits, try 4*root+1
    assign cur   = {rem_in, rad_in[63:62]};
    assign trial = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (cur >= trial) begin
        rem_r[k]  <= 34'(cur - trial);
        root_r[k] <= {root_in[30:0], 1'b1};
      end else begin
        rem_r[k]  <= cur[33:0];
        root_r[k] <= {root_in[30:0], 1'b0};
      end
      rad_r[k] <= {rad_in[61:0], 2'b00};
    end
  end

  assign root = root_r[SQRT_STAGES-1];
endmodule
`default_nettype wire

// ===== hw/rtl/cir_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cir_div
// Pipelined restoring divider, one quotient bit per stage. The quotient must
// fit in Q_W bits; a zero divisor gives a meaningless quotient.
// ----------------------------------------------------------------------------
module cir_div #(
  parameter int NUM_W = 62,
  parameter int DEN_W = 33,
  parameter int Q_W   = 31
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quo
);
  logic [DEN_W-1:0] rem_r [Q_W];
  logic [Q_W-1:0]   low_r [Q_W];
  logic [DEN_W-1:0] den_r [Q_W];
  logic [Q_W-1:0]   quo_r [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   low_in;
    logic [Q_W-1:0]   quo_in;
    logic [DEN_W:0]   trial;

    if (k == 0) begin : g_first
      assign rem_in = DEN_W'(num >> Q_W);
      assign low_in = num[Q_W-1:0];
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign low_in = low_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    assign trial = {rem_in, low_in[Q_W-1]};

    always_ff @(posedge clk) begin
      if (trial >= {1'b0, den_in}) begin
        rem_r[k] <= DEN_W'(trial - {1'b0, den_in});
        quo_r[k] <= {quo_in[Q_W-2:0], 1'b1};
      end else begin
        rem_r[k] <= trial[DEN_W-1:0];
        quo_r[k] <= {quo_in[Q_W-2:0], 1'b0};
      end
      low_r[k] <= {low_in[Q_W-2:0], 1'b0};
      den_r[k] <= den_in;
    end
  end

  assign quo = quo_r[Q_W-1];
endmodule
`default_nettype wire

// ===== hw/rtl/collision_impulse_response_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// collision_impulse_response_top
// The path from start to done runs through the 32-stage square root and the
// FRAC_BITS+1 stage normalize divider.
// Throughput: one word per cycle; busy stays low, the pipeline never stalls.
// Reset: clears all valid bits (words in flight are dropped) and loads
// restitution 16384 and rest_threshold 7.
// ----------------------------------------------------------------------------
module collision_impulse_response_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  cir_pkg::item_t               item,
  output logic                         done,
  output cir_pkg::result_t             result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cir_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import cir_pkg::*;

  localparam int ITEM_W    = $bits(item_t);
  localparam int NUM_W     = DATA_W + FRAC_BITS;
  localparam int QN_W      = FRAC_BITS + 1;
  // squares and their sum take two stages ahead of the root
  localparam int LEN_LAT   = SQRT_STAGES + 2;
  localparam int FRONT_LAT = LEN_LAT + QN_W;
  localparam int RNUM_W    = DATA_W + RATIO_BITS;
  localparam int RQ_W      = RATIO_BITS + 1;
  localparam int RDLY      = 8 + QN_W;
  localparam int P_STAGES  = 10;
  localparam int MAG_W     = 66 - FRAC_BITS;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? 32'(32'd0 - v) : v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7fffffff;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // ---------------- configuration ----------------
  logic [REST_W-1:0] restitution;
  logic [THR_W-1:0]  rest_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      restitution    <= RESTITUTION_RESET;
      rest_threshold <= REST_THRESHOLD_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[PADDR_W-1])
        REG_RESTITUTION:    restitution    <= pwdata[REST_W-1:0];
        REG_REST_THRESHOLD: rest_threshold <= pwdata[THR_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[PADDR_W-1])
      REG_RESTITUTION:    prdata = 32'(restitution);
      REG_REST_THRESHOLD: prdata = 32'(rest_threshold);
    endcase
  end

  assign pready = 1'b1;
  assign busy   = 1'b0;

  // ---------------- input register and valid line ----------------
  logic                 in_v;
  item_t                in_r;
  logic [FRONT_LAT-1:0] front_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v    <= 1'b0;
      front_v <= '0;
    end else begin
      in_v    <= start && !busy;
      front_v <= {front_v[FRONT_LAT-2:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    in_r <= item;
  end

  // ---------------- direction length ----------------
  vec3_t       dir_in;
  logic [63:0] sq_r [3];
  logic [63:0] s_r;
  logic [31:0] len;

  assign dir_in[0] = in_r.dir_x;
  assign dir_in[1] = in_r.dir_y;
  assign dir_in[2] = in_r.dir_z;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq_r[i] <= 64'(mag32(dir_in[i])) * 64'(mag32(dir_in[i]));
    end
    s_r <= sq_r[0] + sq_r[1] + sq_r[2];
  end

  cir_sqrt u_sqrt (
    .clk  (clk),
    .rad  (s_r),
    .root (len)
  );

  item_t a_item;
  vec3_t dir_a;

  cir_delay #(.W(ITEM_W), .DEPTH(LEN_LAT)) u_dly_a (
    .clk (clk),
    .d   (in_r),
    .q   (a_item)
  );

  assign dir_a[0] = a_item.dir_x;
  assign dir_a[1] = a_item.dir_y;
  assign dir_a[2] = a_item.dir_z;

  // ---------------- normalize: |d| * 2^F / len per axis ----------------
  logic [QN_W-1:0] q_n [3];

  for (genvar i = 0; i < 3; i++) begin : g_norm
    cir_div #(.NUM_W(NUM_W), .DEN_W(DATA_W), .Q_W(QN_W)) u_div (
      .clk (clk),
      .num ({mag32(dir_a[i]), {FRAC_BITS{1'b0}}}),
      .den (len),
      .quo (q_n[i])
    );
  end

  logic [ITEM_W:0] b_bus;
  item_t           b_item;
  logic            b_zero;
  vec3_t           dir_b;

  cir_delay #(.W(ITEM_W + 1), .DEPTH(QN_W)) u_dly_b (
    .clk (clk),
    .d   ({a_item, len == '0}),
    .q   (b_bus)
  );

  assign b_item   = b_bus[ITEM_W:1];
  assign b_zero   = b_bus[0];
  assign dir_b[0] = b_item.dir_x;
  assign dir_b[1] = b_item.dir_y;
  assign dir_b[2] = b_item.dir_z;

  // ---------------- mass ratios ----------------
  logic [32:0]         msum_r;
  logic [RNUM_W-1:0]   num_ra_r;
  logic [RNUM_W-1:0]   num_rb_r;
  logic [RQ_W-1:0]     ra_q;
  logic [RQ_W-1:0]     rb_q;
  logic [2*RQ_W-1:0]   ratio_d;
  logic [RQ_W-1:0]     ra_d;
  logic [RQ_W-1:0]     rb_d;

  always_ff @(posedge clk) begin
    msum_r   <= 33'(in_r.mass_a) + 33'(in_r.mass_b);
    num_ra_r <= {in_r.mass_b, {RATIO_BITS{1'b0}}};
    num_rb_r <= {in_r.mass_a, {RATIO_BITS{1'b0}}};
  end

  cir_div #(.NUM_W(RNUM_W), .DEN_W(33), .Q_W(RQ_W)) u_div_ra (
    .clk (clk),
    .num (num_ra_r),
    .den (msum_r),
    .quo (ra_q)
  );

  cir_div #(.NUM_W(RNUM_W), .DEN_W(33), .Q_W(RQ_W)) u_div_rb (
    .clk (clk),
    .num (num_rb_r),
    .den (msum_r),
    .quo (rb_q)
  );

  // hold ratios until the impulse magnitude arrives
  cir_delay #(.W(2 * RQ_W), .DEPTH(RDLY)) u_dly_r (
    .clk (clk),
    .d   ({ra_q, rb_q}),
    .q   (ratio_d)
  );

  assign ra_d = ratio_d[2*RQ_W-1:RQ_W];
  assign rb_d = ratio_d[RQ_W-1:0];

  // ---------------- back pipeline ----------------
  logic [P_STAGES-1:0] pv;
  carry_t              cr [P_STAGES];
  carry_t              p0_next;
  carry_t              c4_next;

  always_comb begin
    p0_next.skip = (b_item.mode != MODE_NORMALIZE && b_item.mode != MODE_UNIT)
                   || (b_item.mass_a == '0 && b_item.mass_b == '0)
                   || (b_item.mode == MODE_NORMALIZE && b_zero);
    p0_next.va[0] = b_item.vel_a_x;
    p0_next.va[1] = b_item.vel_a_y;
    p0_next.va[2] = b_item.vel_a_z;
    p0_next.vb[0] = b_item.vel_b_x;
    p0_next.vb[1] = b_item.vel_b_y;
    p0_next.vb[2] = b_item.vel_b_z;
    for (int i = 0; i < 3; i++) begin
      if (b_item.mode == MODE_NORMALIZE) begin
        p0_next.u[i] = dir_b[i][31] ? 32'(32'd0 - 32'(q_n[i])) : 32'(q_n[i]);
      end else begin
        p0_next.u[i] = dir_b[i];
      end
    end
  end

  logic quiet;

  // resting or separating pairs pass through unchanged
  always_comb begin
    c4_next      = cr[3];
    c4_next.skip = cr[3].skip | quiet;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv   <= '0;
      done <= 1'b0;
    end else begin
      pv   <= {pv[P_STAGES-2:0], front_v[FRONT_LAT-1]};
      done <= pv[P_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    cr[0] <= p0_next;
    for (int k = 1; k < P_STAGES; k++) begin
      cr[k] <= (k == 4) ? c4_next : cr[k-1];
    end
  end

  // projections
  logic signed [63:0] prod_a [3];
  logic signed [63:0] prod_b [3];
  logic signed [65:0] sum_a;
  logic signed [65:0] sum_b;
  logic signed [65:0] proj_a_r;
  logic signed [65:0] proj_b_r;
  logic signed [31:0] pa_r;
  logic signed [31:0] pb_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      prod_a[i] <= $signed(cr[0].u[i]) * $signed(cr[0].va[i]);
      prod_b[i] <= $signed(cr[0].u[i]) * $signed(cr[0].vb[i]);
    end
  end

  assign sum_a = 66'(prod_a[0]) + 66'(prod_a[1]) + 66'(prod_a[2]);
  assign sum_b = 66'(prod_b[0]) + 66'(prod_b[1]) + 66'(prod_b[2]);

  always_ff @(posedge clk) begin
    proj_a_r <= sum_a >>> FRAC_BITS;
    proj_b_r <= sum_b >>> FRAC_BITS;
    pa_r     <= sat32(proj_a_r);
    pb_r     <= sat32(proj_b_r);
  end

  // approach test and closing speed
  logic signed [32:0] pa_ext;
  logic signed [32:0] pb_ext;
  logic [32:0]        pa_mag;
  logic [32:0]        pb_mag;
  logic signed [32:0] diff;
  logic [31:0]        diff_r;

  assign pa_ext = 33'(pa_r);
  assign pb_ext = 33'(pb_r);
  assign pa_mag = pa_r[31] ? 33'(-pa_ext) : 33'(pa_ext);
  assign pb_mag = pb_r[31] ? 33'(-pb_ext) : 33'(pb_ext);
  assign quiet  = (pa_mag < 33'(rest_threshold) && pb_mag < 33'(rest_threshold))
                  || (pa_r < pb_r);
  assign diff   = pa_ext - pb_ext;

  always_ff @(posedge clk) begin
    diff_r <= diff[31:0];
  end

  // impulse magnitude
  logic [15:0] rest_k;
  logic [47:0] t_full;
  logic [33:0] t_r;
  logic [47:0] pp_ah;
  logic [47:0] pp_al;
  logic [47:0] pp_bh;
  logic [47:0] pp_bl;
  logic [65:0] dsum_a;
  logic [65:0] dsum_b;
  logic [33:0] da_r;
  logic [33:0] db_r;

  assign rest_k = 16'(REST_ONE) + 16'(restitution);
  assign t_full = 48'(diff_r) * 48'(rest_k);
  assign dsum_a = {1'b0, pp_ah, 17'd0} + 66'(pp_al);
  assign dsum_b = {1'b0, pp_bh, 17'd0} + 66'(pp_bl);

  always_ff @(posedge clk) begin
    t_r   <= t_full[47:14];
    pp_ah <= 48'(t_r[33:17]) * 48'(ra_d);
    pp_al <= 48'(t_r[16:0]) * 48'(ra_d);
    pp_bh <= 48'(t_r[33:17]) * 48'(rb_d);
    pp_bl <= 48'(t_r[16:0]) * 48'(rb_d);
    da_r  <= dsum_a[63:30];
    db_r  <= dsum_b[63:30];
  end

  // per-axis impulse
  logic [31:0]      um [3];
  logic [48:0]      ma_hi [3];
  logic [48:0]      ma_lo [3];
  logic [48:0]      mb_hi [3];
  logic [48:0]      mb_lo [3];
  logic [66:0]      full_a [3];
  logic [66:0]      full_b [3];
  logic [MAG_W-1:0] mag_a_r [3];
  logic [MAG_W-1:0] mag_b_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      um[i]     = mag32(cr[7].u[i]);
      full_a[i] = {1'b0, ma_hi[i], 17'd0} + 67'(ma_lo[i]);
      full_b[i] = {1'b0, mb_hi[i], 17'd0} + 67'(mb_lo[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      ma_hi[i]   <= 49'(da_r[33:17]) * 49'(um[i]);
      ma_lo[i]   <= 49'(da_r[16:0]) * 49'(um[i]);
      mb_hi[i]   <= 49'(db_r[33:17]) * 49'(um[i]);
      mb_lo[i]   <= 49'(db_r[16:0]) * 49'(um[i]);
      mag_a_r[i] <= MAG_W'(full_a[i] >> FRAC_BITS);
      mag_b_r[i] <= MAG_W'(full_b[i] >> FRAC_BITS);
    end
  end

  // apply and saturate
  logic signed [65:0] va66 [3];
  logic signed [65:0] vb66 [3];
  logic signed [65:0] ma66 [3];
  logic signed [65:0] mb66 [3];
  logic signed [31:0] new_a [3];
  logic signed [31:0] new_b [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      va66[i] = 66'($signed(cr[9].va[i]));
      vb66[i] = 66'($signed(cr[9].vb[i]));
      ma66[i] = 66'(mag_a_r[i]);
      mb66[i] = 66'(mag_b_r[i]);
      if (cr[9].skip) begin
        new_a[i] = $signed(cr[9].va[i]);
        new_b[i] = $signed(cr[9].vb[i]);
      end else if (cr[9].u[i][31]) begin
        new_a[i] = sat32(va66[i] + ma66[i]);
        new_b[i] = sat32(vb66[i] - mb66[i]);
      end else begin
        new_a[i] = sat32(va66[i] - ma66[i]);
        new_b[i] = sat32(vb66[i] + mb66[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    result.new_a_x  <= new_a[0];
    result.new_a_y  <= new_a[1];
    result.new_a_z  <= new_a[2];
    result.new_b_x  <= new_b[0];
    result.new_b_y  <= new_b[1];
    result.new_b_z  <= new_b[2];
    result.collided <= !cr[9].skip;
  end

endmodule
`default_nettype wire
